>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define BHFL_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define BHFL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/bhfl_pkg.sv
// ----------------------------------------------------------------------------
// Block heap free list package
// Operation and status codes, sequencer states and the update commands that
// the control logic sends to the key table and the free stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhfl_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_STORE = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_FREED     = 3'd2,
    ST_NO_BLOCK  = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_OFFSET    = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Update of the per-key table: length write on alloc, freed mark on
  // alloc and free.
  typedef struct packed {
    logic       len_wr;
    logic       mark_wr;
    logic       mark_val;
    logic [5:0] key;
    logic [8:0] len;
  } kt_cmd_t;

  // Update of the free stack.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [5:0] key;
  } fs_cmd_t;

endpackage

>>> rtl/bhfl_key_table.sv
// ----------------------------------------------------------------------------
// Key table
// Block lengths in a synchronous memory and freed marks in flip-flops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhfl_key_table #(
  parameter int unsigned KEY_BITS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [5:0]          rd_key,
  input  logic [5:0]          mark_key,
  input  bhfl_pkg::kt_cmd_t   cmd,
  output logic                mark,
  output logic [8:0]          len
);
  import bhfl_pkg::*;

  localparam int unsigned ENTRIES = 2 ** KEY_BITS;

  logic [ENTRIES-1:0] marks_r;
  logic [8:0]         len_mem [ENTRIES];
  logic [8:0]         len_q_r;

  // Freed marks reset to zero, so they live in flip-flops.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
    end else if (cmd.mark_wr) begin
      marks_r[cmd.key[KEY_BITS-1:0]] <= cmd.mark_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_wr) begin
      len_mem[cmd.key[KEY_BITS-1:0]] <= cmd.len;
    end
    if (rd_en) begin
      len_q_r <= len_mem[rd_key[KEY_BITS-1:0]];
    end
  end

  assign mark = marks_r[mark_key[KEY_BITS-1:0]];
  assign len  = len_q_r;

endmodule

>>> rtl/bhfl_free_stack.sv
// ----------------------------------------------------------------------------
// Free stack
// LIFO of released keys in a synchronous memory with its fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhfl_free_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  bhfl_pkg::fs_cmd_t cmd,
  output logic              empty,
  output logic              full,
  output logic [5:0]        top_key
);
  import bhfl_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned SB = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [5:0]    stk_mem [2 ** SB];
  logic [5:0]    top_q_r;
  logic [SB-1:0] top_addr;

  assign top_addr = SB'(count_r - 1'b1);
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // The top entry is read when a request is taken; pushes and pops happen
  // in the cycle after, so a read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[SB'(count_r)] <= cmd.key;
    end
    if (rd_en) begin
      top_q_r <= stk_mem[top_addr];
    end
  end

  assign top_key = top_q_r;

  `BHFL_ASSERT_IMP(a_no_pop_empty, cmd.pop, !empty, "free stack popped while empty")
  `BHFL_ASSERT_IMP(a_no_push_full, cmd.push, !full && !cmd.pop, "free stack push when full")
  `BHFL_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "free stack count past depth")

endmodule

>>> rtl/bhfl_word_store.sv
// ----------------------------------------------------------------------------
// Word store
// Synchronous 64-bit data memory addressed by key and word offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhfl_word_store #(
  parameter int unsigned ADDR_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [63:0]          wr_data,
  output logic [63:0]          rd_data
);
  import bhfl_pkg::*;

  logic [63:0] mem [2 ** ADDR_BITS];
  logic [63:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

>>> rtl/block_heap_free_list_checker_core.sv
// ----------------------------------------------------------------------------
// Block heap free list checker core
// Handle-based heap with a LIFO free list and checked word access.
// ----------------------------------------------------------------------------
// A request is registered at its transfer edge, where the memory reads also
// start; the EXEC state then checks it and does its writes, and the result
// registers take the outcome. Busy holds off the next request until EXEC
// has ended, and results cannot be stalled.
// Reset (synchronous, active low) empties the free stack, clears all freed
// marks and restarts key issue at zero; memories need no clearing pass.
`timescale 1ns / 1ps

module block_heap_free_list_checker_core #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned MAX_WORDS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_block_key,
  input  logic [7:0]  in_word_offset,
  input  logic [8:0]  in_block_size,
  input  logic [63:0] in_write_value,
  output logic        out_valid,
  output logic [5:0]  out_new_key,
  output logic [63:0] out_read_value,
  output logic [2:0]  out_status
);
  import bhfl_pkg::*;

  `include "assert_macros.svh"

  // Request fields carry six key bits, so only keys below 64 can ever be
  // named by free, store or load. Keys issued above that are counted but
  // never need a table entry.
  localparam int unsigned NK    = (MAX_BLOCKS < 64) ? MAX_BLOCKS : 64;
  localparam int unsigned KB    = $clog2(NK);
  localparam int unsigned WL2   = $clog2(MAX_WORDS);
  // Offset bits that can pass the length check: below MAX_WORDS and 256.
  localparam int unsigned OW    = (WL2 < 1) ? 1 : ((WL2 > 8) ? 8 : WL2);
  localparam int unsigned FW    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CMPW  = (FW > 6) ? FW : 6;

  // Sequencer and request registers.
  state_t        state_r;
  state_t        state_nxt;
  logic          accept;

  op_t           op_r;
  logic [5:0]    key_r;
  logic [7:0]    off_r;
  logic [8:0]    size_r;
  logic [63:0]   wval_r;

  logic [FW-1:0] fresh_r;
  logic [FW-1:0] fresh_nxt;

  // Result registers.
  logic          out_valid_r;
  logic [5:0]    out_new_key_r;
  logic [63:0]   out_read_value_r;
  status_t       out_status_r;

  status_t       res_status;
  logic [5:0]    res_key;
  logic [63:0]   res_rdata;

  // Submodule traffic.
  kt_cmd_t       kt_cmd;
  fs_cmd_t       fs_cmd;
  logic          kt_mark;
  logic [8:0]    kt_len;
  logic          fs_empty;
  logic          fs_full;
  logic [5:0]    fs_top;
  logic          ws_we;
  logic [63:0]   ws_rdata;

  logic          key_valid;
  logic          size_ok;
  logic          off_in_range;

  // Result checks for the assertions at the end.
  logic          out_err;
  logic          out_payload_zero;

  // A transfer is taken only in IDLE. All memory reads are launched at the transfer
  // edge, the free stack's from its count and the others from the input ports; all
  // writes happen at the end of the following EXEC cycle. Since busy stays high through
  // EXEC, a read and a write of the same entry never share an edge and no forwarding is needed.
  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      key_r  <= in_block_key;
      off_r  <= in_word_offset;
      size_r <= in_block_size;
      wval_r <= in_write_value;
    end
  end

  // A key is valid once it has been issued; that also keeps it below
  // MAX_BLOCKS, since issue stops there.
  assign key_valid    = (CMPW'(key_r) < CMPW'(fresh_r));
  assign size_ok      = (32'(size_r) <= 32'(MAX_WORDS));
  assign off_in_range = ({1'b0, off_r} < kt_len);

  always_comb begin
    state_nxt  = state_r;
    fresh_nxt  = fresh_r;
    kt_cmd     = '0;
    fs_cmd     = '0;
    ws_we      = 1'b0;
    res_status = ST_OK;
    res_key    = '0;
    res_rdata  = '0;
    kt_cmd.key = key_r;
    kt_cmd.len = size_r;
    fs_cmd.key = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (op_r) inside
          OP_ALLOC: begin
            if (!size_ok) begin
              res_status = ST_TOO_LARGE;
            end else if (!fs_empty) begin
              // Reuse the most recently released key.
              fs_cmd.pop     = 1'b1;
              res_key        = fs_top;
              kt_cmd.key     = fs_top;
              kt_cmd.len_wr  = 1'b1;
              kt_cmd.mark_wr = 1'b1;
            end else if (fresh_r < FW'(MAX_BLOCKS)) begin
              fresh_nxt  = fresh_r + 1'b1;
              res_key    = 6'(fresh_r);
              kt_cmd.key = 6'(fresh_r);
              // Keys beyond the six-bit range are never looked up again.
              if (fresh_r < FW'(NK)) begin
                kt_cmd.len_wr  = 1'b1;
                kt_cmd.mark_wr = 1'b1;
              end
            end else begin
              res_status = ST_NO_BLOCK;
            end
          end
          OP_FREE: begin
            if (!key_valid || (off_r != '0)) begin
              res_status = ST_INVALID;
            end else if (kt_mark) begin
              res_status = ST_FREED;
            end else if (!fs_full) begin
              fs_cmd.push     = 1'b1;
              kt_cmd.mark_wr  = 1'b1;
              kt_cmd.mark_val = 1'b1;
            end
          end
          OP_STORE, OP_LOAD: begin
            if (!key_valid) begin
              res_status = ST_INVALID;
            end else if (kt_mark) begin
              res_status = ST_FREED;
            end else if (!off_in_range) begin
              res_status = ST_OFFSET;
            end else if (op_r == OP_STORE) begin
              ws_we = 1'b1;
            end else begin
              res_rdata = ws_rdata;
            end
          end
          default: begin
            res_status = ST_OK;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fresh_r     <= fresh_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      out_new_key_r    <= res_key;
      out_read_value_r <= res_rdata;
      out_status_r     <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_key    = out_new_key_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  bhfl_key_table #(
    .KEY_BITS (KB)
  ) u_key_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_key   (in_block_key),
    .mark_key (key_r),
    .cmd      (kt_cmd),
    .mark     (kt_mark),
    .len      (kt_len)
  );

  bhfl_free_stack #(
    .DEPTH (NK)
  ) u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .cmd     (fs_cmd),
    .empty   (fs_empty),
    .full    (fs_full),
    .top_key (fs_top)
  );

  // Word address is key and offset side by side; offsets that pass the
  // length check always fit in the low field.
  bhfl_word_store #(
    .ADDR_BITS (KB + OW)
  ) u_word_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr ({in_block_key[KB-1:0], in_word_offset[OW-1:0]}),
    .wr_en   (ws_we),
    .wr_addr ({key_r[KB-1:0], off_r[OW-1:0]}),
    .wr_data (wval_r),
    .rd_data (ws_rdata)
  );

  assign out_err          = out_valid && (out_status != ST_OK);
  assign out_payload_zero = (out_new_key == '0) && (out_read_value == '0);

  `BHFL_ASSERT_IMP(a_strobe_after_exec, out_valid, $past(busy), "result strobe without a request")
  `BHFL_ASSERT_IMP(a_error_zero_payload, out_err, out_payload_zero, "error result carries payload")
  `BHFL_ASSERT(a_fresh_bound, fresh_r <= FW'(MAX_BLOCKS), "fresh key count past the limit")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Block heap free list checker core testbench
// Sends alloc, free, store and load requests to the heap core and checks
// every result against the one written in its directed row or against a
// predictor of the key table, the free stack and the word store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import bhfl_pkg::*;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned MAX_WORDS    = 256;
  localparam int          RANDOM_ITEMS = 1650;
  localparam int          PHASE_LEN    = 150;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          REPORT_MAX   = 10;

  // One request as it goes onto the input ports.
  typedef struct packed {
    op_t         op;
    logic [5:0]  key;
    logic [7:0]  off;
    logic [8:0]  size;
    logic [63:0] wval;
  } heap_req_t;

  // One result as it comes off the result ports.
  typedef struct packed {
    logic [5:0]  new_key;
    logic [63:0] read_value;
    status_t     status;
  } heap_result_t;

  // A directed row. When typed is set, the expected result is the one
  // written in the row; otherwise the predictor supplies it.
  typedef struct packed {
    heap_req_t    req;
    logic         typed;
    heap_result_t res;
  } dir_row_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [1:0]  in_operation   = '0;
  logic [5:0]  in_block_key   = '0;
  logic [7:0]  in_word_offset = '0;
  logic [8:0]  in_block_size  = '0;
  logic [63:0] in_write_value = '0;
  logic        busy;
  logic        out_valid;
  logic [5:0]  out_new_key;
  logic [63:0] out_read_value;
  logic [2:0]  out_status;

  // Predicted heap state. It follows every accepted request in order.
  int unsigned next_key;
  int unsigned free_depth;
  bit [5:0]    free_keys   [MAX_BLOCKS];
  bit          freed       [MAX_BLOCKS];
  bit [8:0]    block_len   [MAX_BLOCKS];
  bit [63:0]   words       [MAX_BLOCKS][MAX_WORDS];
  // Words stored since the latest alloc of their block. A load that would
  // pass every check is only ever sent to a word whose bit is set here.
  bit          written     [MAX_BLOCKS][MAX_WORDS];

  heap_result_t awaited_results[$];
  dir_row_t     dir_rows[$];
  heap_result_t head_result;
  int           mismatch_count = 0;
  int           stall_cycles   = 0;
  bit           no_idle        = 1'b0;

  block_heap_free_list_checker_core #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .MAX_WORDS (MAX_WORDS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_block_key  (in_block_key),
    .in_word_offset(in_word_offset),
    .in_block_size (in_block_size),
    .in_write_value(in_write_value),
    .out_valid     (out_valid),
    .out_new_key   (out_new_key),
    .out_read_value(out_read_value),
    .out_status    (out_status)
  );

  always #5 clk = ~clk;

  // Appends a row to the directed table.
  function automatic void add_row(dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // Appends a result to the tail of the awaited results.
  function automatic void await_result(heap_result_t want);
    awaited_results = {awaited_results, want};
  endfunction

  // --------------------------------------------------------------------------
  // Heap predictor. Applies one request to the predicted state and returns
  // the result the core must give for it. Error results leave the state as
  // it was and carry zero in new_key and read_value.
  // --------------------------------------------------------------------------
  function automatic heap_result_t compute_heap_result(heap_req_t r);
    heap_result_t res;
    int unsigned  k;
    bit           granted;
    res     = '{6'd0, 64'd0, ST_OK};
    granted = 1'b0;
    k       = 0;
    case (r.op)
      OP_ALLOC: begin
        if (r.size > MAX_WORDS) begin
          res.status = ST_TOO_LARGE;
        end else if (free_depth > 0) begin
          // The most recently freed key comes back first.
          free_depth--;
          k       = free_keys[free_depth];
          granted = 1'b1;
        end else if (next_key < MAX_BLOCKS) begin
          k       = next_key;
          next_key++;
          granted = 1'b1;
        end else begin
          res.status = ST_NO_BLOCK;
        end
        if (granted) begin
          freed[k]     = 1'b0;
          block_len[k] = r.size;
          for (int w = 0; w < MAX_WORDS; w++) written[k][w] = 1'b0;
          res.new_key  = 6'(k);
        end
      end
      OP_FREE: begin
        if (r.key >= next_key || r.off != 0) begin
          res.status = ST_INVALID;
        end else if (freed[r.key]) begin
          res.status = ST_FREED;
        end else begin
          freed[r.key]          = 1'b1;
          free_keys[free_depth] = r.key;
          free_depth++;
        end
      end
      default: begin
        if (r.key >= next_key) begin
          res.status = ST_INVALID;
        end else if (freed[r.key]) begin
          res.status = ST_FREED;
        end else if (r.off >= block_len[r.key]) begin
          res.status = ST_OFFSET;
        end else if (r.op == OP_STORE) begin
          words[r.key][r.off]   = r.wval;
          written[r.key][r.off] = 1'b1;
        end else begin
          res.read_value = words[r.key][r.off];
        end
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random request generation. Keys mostly name live blocks and offsets
  // mostly fall inside them, so that most requests get past the checks; a
  // tenth of keys and of non-free offsets are drawn from the whole field as
  // noise. The phase shifts the mix between alloc-heavy, access-heavy and
  // free-heavy, which drives the key space to exhaustion and back.
  // --------------------------------------------------------------------------
  function automatic logic [5:0] pick_key();
    logic [5:0] k;
    k = 6'($urandom_range(63));
    if ($urandom_range(9) == 0 || next_key == 0) return k;
    for (int t = 0; t < 8; t++) begin
      k = 6'($urandom_range(next_key - 1));
      if (!freed[k]) return k;
    end
    return k;
  endfunction

  function automatic heap_req_t draw_request(int phase);
    heap_req_t   r;
    int unsigned roll;
    int unsigned alloc_w;
    int unsigned free_w;
    int unsigned store_w;
    case (phase)
      0:       begin alloc_w = 60; free_w = 10; store_w = 20; end
      1:       begin alloc_w = 10; free_w = 10; store_w = 40; end
      default: begin alloc_w = 10; free_w = 50; store_w = 20; end
    endcase
    roll = $urandom_range(99);
    if (roll < alloc_w)                          r.op = OP_ALLOC;
    else if (roll < alloc_w + free_w)            r.op = OP_FREE;
    else if (roll < alloc_w + free_w + store_w)  r.op = OP_STORE;
    else                                         r.op = OP_LOAD;

    r.key = pick_key();

    roll = $urandom_range(99);
    if (roll < 78)      r.size = 9'($urandom_range(8));
    else if (roll < 90) r.size = 9'($urandom_range(256, 9));
    else if (roll < 95) r.size = 9'(MAX_WORDS);
    else                r.size = 9'($urandom_range(511, 257));

    case ($urandom_range(9))
      0:       r.wval = '0;
      1:       r.wval = '1;
      default: r.wval = {$urandom, $urandom};
    endcase

    if (r.op == OP_FREE) begin
      r.off = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 1)) : 8'd0;
    end else if ($urandom_range(9) == 0 || r.key >= next_key || block_len[r.key] == 0) begin
      r.off = 8'($urandom_range(255));
    end else begin
      r.off = 8'($urandom_range(block_len[r.key] - 1));
    end

    // A load that would pass every check must hit a word stored since the
    // block's latest alloc; otherwise it becomes a store to that word.
    if (r.op == OP_LOAD && r.key < next_key && !freed[r.key] &&
        r.off < block_len[r.key] && !written[r.key][r.off]) begin
      r.op = OP_STORE;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Called at the clock edge of the previous transfer, or right
  // after reset or a drain. It may leave start low for a random number of
  // cycles, then holds the request on the ports until the edge at which it
  // transfers. Start is given a single nonblocking assignment per time step.
  // --------------------------------------------------------------------------
  task automatic send_request(heap_req_t r);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < 29) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation   <= r.op;
    in_block_key   <= r.key;
    in_word_offset <= r.off;
    in_block_size  <= r.size;
    in_write_value <= r.wval;
    start          <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
  endtask

  // Holds the sender back until every awaited result has come. The queue is
  // looked at on the falling edge so that the checker's pop at the rising
  // edge has always happened first.
  task automatic drain_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic flag_result(string why, heap_result_t want);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0t: %s: expected key %0d value %h status %0d, got key %0d value %h status %0d",
               $realtime, why, want.new_key, want.read_value, want.status,
               out_new_key, out_read_value, out_status);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker. A result is on the ports for one cycle and is taken at
  // the edge that ends it. Each one is compared field by field with the
  // oldest awaited result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        flag_result("result with nothing awaited", '{6'd0, 64'd0, ST_OK});
      end else begin
        head_result = awaited_results.pop_front();
        if (out_new_key !== head_result.new_key ||
            out_read_value !== head_result.read_value ||
            out_status !== head_result.status) begin
          flag_result("result mismatch", head_result);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. Counts cycles in which neither a request nor a result
  // transfers. The sender's gaps are short and a result follows its request
  // straight through the EXEC state and the result registers, so a long
  // silence means the core has hung.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[block_heap_free_list_checker_core] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed rows, the random part, then the drain.
  // --------------------------------------------------------------------------
  initial begin
    heap_req_t    req;
    heap_result_t res;

    next_key   = 0;
    free_depth = 0;

    // Directed rows, starting from the state right after reset. They cover
    // every operation, the all-zero and all-one corners of the fields, an
    // oversize alloc, a zero-size block, keys never issued, a free with an
    // offset, a double free, access to a freed block, an offset past the
    // block and reuse of the latest freed key.
    add_row(dir_row_t'{'{OP_LOAD, 6'd0, 8'd0, 9'd0, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_INVALID}});
    add_row(dir_row_t'{'{OP_FREE, 6'd0, 8'd0, 9'd0, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_INVALID}});
    add_row(dir_row_t'{'{OP_STORE, 6'd63, 8'd255, 9'd511, '1},
                       1'b1, '{6'd0, 64'd0, ST_INVALID}});
    add_row(dir_row_t'{'{OP_ALLOC, 6'd63, 8'd255, 9'd511, '1},
                       1'b1, '{6'd0, 64'd0, ST_TOO_LARGE}});
    add_row(dir_row_t'{'{OP_ALLOC, 6'd0, 8'd0, 9'd257, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_TOO_LARGE}});
    add_row(dir_row_t'{'{OP_ALLOC, 6'd0, 8'd0, 9'd256, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_ALLOC, 6'd0, 8'd0, 9'd0, 64'd0},
                       1'b1, '{6'd1, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_STORE, 6'd1, 8'd0, 9'd0, 64'd7},
                       1'b1, '{6'd0, 64'd0, ST_OFFSET}});
    add_row(dir_row_t'{'{OP_LOAD, 6'd1, 8'd0, 9'd0, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_OFFSET}});
    add_row(dir_row_t'{'{OP_STORE, 6'd0, 8'd255, 9'd0, '1},
                       1'b1, '{6'd0, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_LOAD, 6'd0, 8'd255, 9'd0, 64'd0},
                       1'b1, '{6'd0, '1, ST_OK}});
    add_row(dir_row_t'{'{OP_STORE, 6'd0, 8'd0, 9'd0, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_LOAD, 6'd0, 8'd0, 9'd0, '1},
                       1'b1, '{6'd0, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_STORE, 6'd2, 8'd0, 9'd0, 64'd1},
                       1'b1, '{6'd0, 64'd0, ST_INVALID}});
    add_row(dir_row_t'{'{OP_FREE, 6'd0, 8'd1, 9'd0, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_INVALID}});
    add_row(dir_row_t'{'{OP_FREE, 6'd0, 8'd0, 9'd0, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_FREE, 6'd0, 8'd0, 9'd0, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_FREED}});
    add_row(dir_row_t'{'{OP_LOAD, 6'd0, 8'd0, 9'd0, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_FREED}});
    add_row(dir_row_t'{'{OP_STORE, 6'd0, 8'd3, 9'd0, 64'd5},
                       1'b1, '{6'd0, 64'd0, ST_FREED}});
    add_row(dir_row_t'{'{OP_ALLOC, 6'd5, 8'd0, 9'd1, 64'd0},
                       1'b1, '{6'd0, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_STORE, 6'd0, 8'd1, 9'd0, 64'd9},
                       1'b1, '{6'd0, 64'd0, ST_OFFSET}});
    add_row(dir_row_t'{'{OP_STORE, 6'd0, 8'd0, 9'd0, 64'hA5A5_5A5A_0F0F_F0F0},
                       1'b0, '{6'd0, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_LOAD, 6'd0, 8'd0, 9'd0, 64'd0},
                       1'b0, '{6'd0, 64'd0, ST_OK}});
    add_row(dir_row_t'{'{OP_ALLOC, 6'd0, 8'd0, 9'd9, 64'd0},
                       1'b0, '{6'd0, 64'd0, ST_OK}});

    // Reset is held from the start and released at a clock edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Each request is predicted at the edge of its transfer, so the
    // predicted state is always up to date when the next one is drawn.
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req);
      res = compute_heap_result(dir_rows[i].req);
      await_result(dir_rows[i].typed ? dir_rows[i].res : res);
    end

    // The sender waits for every result here and once more in the middle of
    // the random part. A long stretch runs with no idle cycles at all.
    drain_results();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      no_idle = (n >= 1000 && n < 1300);
      req = draw_request((n / PHASE_LEN) % 3);
      send_request(req);
      await_result(compute_heap_result(req));
    end

    // Nothing more is sent; the last results drain, and the clock runs on
    // so that a stray strobe would still be caught.
    drain_results();
    repeat (4) @(posedge clk);
    mismatch_count += awaited_results.size();
    if (mismatch_count == 0) begin
      $display("[block_heap_free_list_checker_core] OK");
    end else begin
      $display("[block_heap_free_list_checker_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bhfl_pkg.sv
rtl/bhfl_key_table.sv
rtl/bhfl_free_stack.sv
rtl/bhfl_word_store.sv
rtl/block_heap_free_list_checker_core.sv
tb/sv/tb_top.sv
